// File: rtl/spa_pkg.sv
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Sizes, command and status codes, the per-slot record and field helpers.
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam int SLOTS   = 1024;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int BIRTH_W = 32;

    // Fixed field widths of the stream words.
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 10;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 11;

    localparam int IN_W    = 16;
    localparam int OUT_W   = 40;
    localparam int IN_PAD  = IN_W - (CMD_W + SLOT_W);
    localparam int OUT_PAD = OUT_W - (STAT_W + 2 * SLOT_W + 1 + COUNT_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_OLDEST  = 2'd2,
        CMD_EVICT   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_INACTIVE = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // Record kept per slot: whether it is active, where it sits in the
    // active list and when it was allocated.
    typedef struct packed {
        logic               active;
        logic [IDX_W-1:0]   pos;
        logic [BIRTH_W-1:0] birth;
    } slot_info_t;

    function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] v);
        logic [IDX_W+SLOT_W-1:0] w;
        w = {{SLOT_W{1'b0}}, v};
        return w[SLOT_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] slot_to_idx(input logic [SLOT_W-1:0] v);
        logic [IDX_W+SLOT_W-1:0] w;
        w = {{IDX_W{1'b0}}, v};
        return w[IDX_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] cnt_to_count(input logic [CNT_W-1:0] v);
        logic [CNT_W+COUNT_W-1:0] w;
        w = {{COUNT_W{1'b0}}, v};
        return w[COUNT_W-1:0];
    endfunction

endpackage

// File: rtl/slot_pool_allocator_evict_oldest_top.sv
// The oldest-slot search reads one list entry a cycle. s_tready rises together
// with the valid of the result word, and a result waiting in the output
// register holds the next word off. After reset an init pass loads all entries
// of both memories before s_tready rises.
// ----------------------------------------------------------------------------
// Slot pool allocator with oldest-first eviction
// One index memory holds the active list at the bottom and the free stack,
// reversed, at the top; a slot memory holds each slot's record.
// ----------------------------------------------------------------------------
module slot_pool_allocator_evict_oldest_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // command [1:0], slot [11:2], zero pad [15:12]
    input  logic [spa_pkg::IN_W-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // status [1:0], slot_out [11:2], evicted_valid [12], evicted_slot [22:13],
    // active_count [33:23], zero pad [39:34]
    output logic [spa_pkg::OUT_W-1:0] m_tdata
);
    import spa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_ALLOC,
        S_SCAN,
        S_DROP0,
        S_DROP1,
        S_DROP2,
        S_DROP3,
        S_DONE
    } state_t;

    localparam int O_SLOT  = STAT_W;
    localparam int O_EV    = O_SLOT + SLOT_W;
    localparam int O_EVS   = O_EV + 1;
    localparam int O_COUNT = O_EVS + SLOT_W;

    state_t                 state_reg;
    cmd_t                   cmd_reg;
    logic [SLOT_W-1:0]      req_reg;
    logic [CNT_W-1:0]       total_reg;
    logic [BIRTH_W-1:0]     next_birth_reg;
    logic [IDX_W-1:0]       clr_reg;

    logic [IDX_W-1:0]       drop_slot_reg;
    logic [IDX_W-1:0]       drop_pos_reg;
    logic [IDX_W-1:0]       moved_reg;
    logic [IDX_W-1:0]       last_reg;

    logic [CNT_W-1:0]       scan_p_reg;
    logic                   v1_reg;
    logic                   v2_reg;
    logic [IDX_W-1:0]       s2_reg;
    logic                   best_valid_reg;
    logic [IDX_W-1:0]       best_slot_reg;
    logic [IDX_W-1:0]       best_pos_reg;
    logic [BIRTH_W-1:0]     best_age_reg;

    status_t                res_status_reg;
    logic [SLOT_W-1:0]      res_slot_reg;
    logic                   res_ev_reg;
    logic [SLOT_W-1:0]      res_evs_reg;

    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       m_tdata_reg;

    // Memories and their ports.
    logic [IDX_W-1:0]       idx_mem [SLOTS];
    slot_info_t             slot_mem [SLOTS];
    logic [IDX_W-1:0]       a_rdata_reg;
    slot_info_t             b_rdata_reg;

    logic                   a_we;
    logic [IDX_W-1:0]       a_wa;
    logic [IDX_W-1:0]       a_wd;
    logic [IDX_W-1:0]       a_ra;
    logic                   b_we;
    logic [IDX_W-1:0]       b_wa;
    slot_info_t             b_wd;
    logic [IDX_W-1:0]       b_ra;

    logic                   full;
    logic                   alloc_now;
    logic                   is_alloc_cmd;
    logic [CNT_W-1:0]       last_w;
    logic                   drop_moves;
    logic                   scan_issue;
    logic [BIRTH_W-1:0]     age;
    logic                   age_better;
    logic                   req_in_range;
    logic                   out_free;

    assign full         = (total_reg == CNT_W'(SLOTS));
    assign is_alloc_cmd = (cmd_reg == CMD_ALLOC) || (cmd_reg == CMD_EVICT);
    assign alloc_now    = ((state_reg == S_DISPATCH) && is_alloc_cmd && !full)
                          || (state_reg == S_ALLOC);
    assign last_w       = total_reg - CNT_W'(1);
    assign drop_moves   = (drop_pos_reg < last_reg);
    assign scan_issue   = (scan_p_reg < total_reg);
    assign age          = next_birth_reg - b_rdata_reg.birth;
    assign age_better   = !best_valid_reg || (age > best_age_reg);
    assign req_in_range = (32'(req_reg) < SLOTS);
    assign out_free     = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Memory port control.
    always_comb
    begin
        a_we = 1'b0;
        a_wa = '0;
        a_wd = '0;
        a_ra = '0;
        b_we = 1'b0;
        b_wa = '0;
        b_wd = '0;
        b_ra = '0;
        case (state_reg)
            S_CLEAR:
            begin
                a_we = 1'b1;
                a_wa = clr_reg;
                a_wd = clr_reg;
                b_we = 1'b1;
                b_wa = clr_reg;
            end
            S_IDLE:
            begin
                // Prefetch the next free slot and the named slot's record.
                a_ra = total_reg[IDX_W-1:0];
                b_ra = slot_to_idx(s_tdata[CMD_W +: SLOT_W]);
            end
            S_SCAN:
            begin
                a_ra = scan_p_reg[IDX_W-1:0];
                b_ra = a_rdata_reg;
            end
            S_DROP0:
            begin
                a_ra = last_w[IDX_W-1:0];
            end
            S_DROP1:
            begin
                b_ra = a_rdata_reg;
                a_we = drop_moves;
                a_wa = drop_pos_reg;
                a_wd = a_rdata_reg;
            end
            S_DROP2:
            begin
                // The released slot goes on top of the free stack.
                a_we = 1'b1;
                a_wa = last_reg;
                a_wd = drop_slot_reg;
                b_we = drop_moves;
                b_wa = moved_reg;
                b_wd = '{active: 1'b1, pos: drop_pos_reg, birth: b_rdata_reg.birth};
            end
            S_DROP3:
            begin
                a_ra = last_reg;
                b_we = 1'b1;
                b_wa = drop_slot_reg;
            end
            default:
            begin
            end
        endcase
        if (alloc_now)
        begin
            b_we = 1'b1;
            b_wa = a_rdata_reg;
            b_wd = '{active: 1'b1, pos: total_reg[IDX_W-1:0], birth: next_birth_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            idx_mem[a_wa] <= a_wd;
        end
        a_rdata_reg <= idx_mem[a_ra];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            slot_mem[b_wa] <= b_wd;
        end
        b_rdata_reg <= slot_mem[b_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cmd_reg        <= CMD_ALLOC;
            req_reg        <= '0;
            total_reg      <= '0;
            next_birth_reg <= '0;
            clr_reg        <= '0;
            drop_slot_reg  <= '0;
            drop_pos_reg   <= '0;
            moved_reg      <= '0;
            last_reg       <= '0;
            scan_p_reg     <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            s2_reg         <= '0;
            best_valid_reg <= 1'b0;
            best_slot_reg  <= '0;
            best_pos_reg   <= '0;
            best_age_reg   <= '0;
            res_status_reg <= ST_OK;
            res_slot_reg   <= '0;
            res_ev_reg     <= 1'b0;
            res_evs_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            if ((state_reg == S_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (alloc_now)
            begin
                total_reg      <= total_reg + CNT_W'(1);
                next_birth_reg <= next_birth_reg + BIRTH_W'(1);
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + IDX_W'(1);
                    if (clr_reg == IDX_W'(SLOTS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg   <= cmd_t'(s_tdata[CMD_W-1:0]);
                        req_reg   <= s_tdata[CMD_W +: SLOT_W];
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    res_ev_reg     <= 1'b0;
                    res_evs_reg    <= '0;
                    scan_p_reg     <= '0;
                    v1_reg         <= 1'b0;
                    v2_reg         <= 1'b0;
                    best_valid_reg <= 1'b0;
                    case (cmd_reg)
                        CMD_ALLOC:
                        begin
                            res_status_reg <= full ? ST_FULL : ST_OK;
                            res_slot_reg   <= full ? '0 : idx_to_slot(a_rdata_reg);
                            state_reg      <= S_DONE;
                        end
                        CMD_EVICT:
                        begin
                            res_status_reg <= ST_OK;
                            res_slot_reg   <= full ? '0 : idx_to_slot(a_rdata_reg);
                            state_reg      <= full ? S_SCAN : S_DONE;
                        end
                        CMD_RELEASE:
                        begin
                            res_slot_reg  <= req_reg;
                            drop_slot_reg <= slot_to_idx(req_reg);
                            drop_pos_reg  <= b_rdata_reg.pos;
                            if (req_in_range && b_rdata_reg.active)
                            begin
                                res_status_reg <= ST_OK;
                                state_reg      <= S_DROP0;
                            end
                            else
                            begin
                                res_status_reg <= ST_INACTIVE;
                                state_reg      <= S_DONE;
                            end
                        end
                        default:
                        begin
                            res_slot_reg <= '0;
                            if (total_reg == '0)
                            begin
                                res_status_reg <= ST_EMPTY;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                res_status_reg <= ST_OK;
                                state_reg      <= S_SCAN;
                            end
                        end
                    endcase
                end
                S_SCAN:
                begin
                    // Three-deep pipeline: list entry, slot record, age compare.
                    v1_reg <= scan_issue;
                    if (scan_issue)
                    begin
                        scan_p_reg <= scan_p_reg + CNT_W'(1);
                    end
                    v2_reg <= v1_reg;
                    s2_reg <= a_rdata_reg;
                    if (v2_reg && age_better)
                    begin
                        best_valid_reg <= 1'b1;
                        best_slot_reg  <= s2_reg;
                        best_pos_reg   <= b_rdata_reg.pos;
                        best_age_reg   <= age;
                    end
                    if (!scan_issue && !v1_reg && !v2_reg)
                    begin
                        drop_slot_reg <= best_slot_reg;
                        drop_pos_reg  <= best_pos_reg;
                        state_reg     <= S_DROP0;
                    end
                end
                S_DROP0:
                begin
                    last_reg  <= last_w[IDX_W-1:0];
                    state_reg <= S_DROP1;
                end
                S_DROP1:
                begin
                    moved_reg <= a_rdata_reg;
                    state_reg <= S_DROP2;
                end
                S_DROP2:
                begin
                    state_reg <= S_DROP3;
                end
                S_DROP3:
                begin
                    total_reg <= last_w;
                    if (cmd_reg == CMD_EVICT)
                    begin
                        res_ev_reg  <= 1'b1;
                        res_evs_reg <= idx_to_slot(drop_slot_reg);
                        state_reg   <= S_ALLOC;
                    end
                    else
                    begin
                        if (cmd_reg == CMD_OLDEST)
                        begin
                            res_slot_reg <= idx_to_slot(drop_slot_reg);
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_ALLOC:
                begin
                    res_slot_reg <= idx_to_slot(a_rdata_reg);
                    state_reg    <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg  <= {{OUT_PAD{1'b0}}, cnt_to_count(total_reg),
                                         res_evs_reg, res_ev_reg, res_slot_reg,
                                         res_status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A full pool is reported only with every slot active.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (m_tdata_reg[STAT_W-1:0] == ST_FULL))
        |-> (m_tdata_reg[O_COUNT +: COUNT_W] == cnt_to_count(CNT_W'(SLOTS))))
        else $error("full status with a free slot left");

    // An empty pool is reported only with no slot active.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (m_tdata_reg[STAT_W-1:0] == ST_EMPTY))
        |-> (m_tdata_reg[O_COUNT +: COUNT_W] == '0))
        else $error("empty status with active slots");

    // An eviction always refills the pool in the same command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tdata_reg[O_EV])
        |-> ((m_tdata_reg[STAT_W-1:0] == ST_OK)
             && (m_tdata_reg[O_COUNT +: COUNT_W] == cnt_to_count(CNT_W'(SLOTS)))))
        else $error("eviction without a full pool after refill");

    // The best age found so far never falls during a search.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && best_valid_reg)
        |=> (best_age_reg >= $past(best_age_reg)))
        else $error("oldest search lost its best age");

endmodule

// File: verif/slot_pool_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot pool checker
// Watches both stream channels and keeps its own copy of the free stack, the
// active list and the birth numbers. It works out each command's result word
// when the command is accepted, and compares the result words in order.
// ----------------------------------------------------------------------------
module slot_pool_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [spa_pkg::IN_W-1:0]  s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [spa_pkg::OUT_W-1:0] m_tdata,
    output int                        fail_count,
    output int                        awaited,
    output int                        pool_level
);
    import spa_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic                evicted;
        logic [SLOT_W-1:0]   evicted_slot;
        logic [COUNT_W-1:0]  count;
    } outcome_t;

    logic [SLOT_W-1:0] free_stack [SLOTS];
    logic [SLOT_W-1:0] active_list [SLOTS];
    logic [SLOT_W-1:0] list_pos [SLOTS];
    logic [31:0]       birth [SLOTS];
    bit                in_use [SLOTS];
    int                free_top;
    int                live;
    logic [31:0]       next_birth;
    outcome_t          awaited_results [$];
    int                errs;

    function automatic void clear_pool();
        for (int i = 0; i < SLOTS; i++) begin
            free_stack[i] = SLOT_W'(SLOTS - 1 - i);
            in_use[i] = 1'b0;
        end
        free_top = SLOTS;
        live = 0;
        next_birth = '0;
    endfunction

    function automatic logic [SLOT_W-1:0] take_free();
        logic [SLOT_W-1:0] s;
        free_top--;
        s = free_stack[free_top];
        birth[s] = next_birth;
        next_birth++;
        list_pos[s] = SLOT_W'(live);
        active_list[live] = s;
        live++;
        in_use[s] = 1'b1;
        return s;
    endfunction

    // The last list entry moves into the hole so the list stays dense.
    function automatic void give_back(logic [SLOT_W-1:0] s);
        int                pos;
        logic [SLOT_W-1:0] moved;
        pos = list_pos[s];
        live--;
        moved = active_list[live];
        if (pos < live) begin
            active_list[pos] = moved;
            list_pos[moved] = SLOT_W'(pos);
        end
        in_use[s] = 1'b0;
        free_stack[free_top] = s;
        free_top++;
    endfunction

    // Age is taken modulo 2^32 so the order survives a wrap of the birth
    // counter; on equal ages the earlier list position is kept.
    function automatic logic [SLOT_W-1:0] oldest_slot();
        logic [SLOT_W-1:0] best;
        logic [31:0]       best_age;
        logic [31:0]       age;
        best = active_list[0];
        best_age = next_birth - birth[best];
        for (int p = 1; p < live; p++) begin
            age = next_birth - birth[active_list[p]];
            if (age > best_age) begin
                best = active_list[p];
                best_age = age;
            end
        end
        return best;
    endfunction

    function automatic outcome_t predict_outcome(cmd_t c, logic [SLOT_W-1:0] s);
        outcome_t r;
        r = '0;
        r.status = ST_OK;
        case (c)
            CMD_ALLOC, CMD_EVICT:
            begin
                if (free_top == 0 && c == CMD_EVICT && live > 0) begin
                    r.evicted_slot = oldest_slot();
                    give_back(r.evicted_slot);
                    r.evicted = 1'b1;
                end
                if (free_top == 0)
                    r.status = ST_FULL;
                else
                    r.slot = take_free();
            end
            CMD_RELEASE:
            begin
                if (in_use[s])
                    give_back(s);
                else
                    r.status = ST_INACTIVE;
                r.slot = s;
            end
            default:
            begin
                if (live == 0) begin
                    r.status = ST_EMPTY;
                end
                else begin
                    r.slot = oldest_slot();
                    give_back(r.slot);
                end
            end
        endcase
        r.count = COUNT_W'(live);
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n) begin
            clear_pool();
            awaited_results.delete();
            errs = 0;
        end
        else begin
            // Results are taken first: a command accepted at this edge cannot
            // have its result word on the output yet.
            if (m_tvalid && m_tready) begin
                got.status       = status_t'(m_tdata[1:0]);
                got.slot         = m_tdata[11:2];
                got.evicted      = m_tdata[12];
                got.evicted_slot = m_tdata[22:13];
                got.count        = m_tdata[33:23];
                if (awaited_results.size() == 0) begin
                    $error("result word with no command waiting: %h", m_tdata);
                    errs++;
                end
                else begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("slot_out", want.slot, got.slot);
                    check_field("evicted_valid", want.evicted, got.evicted);
                    check_field("evicted_slot", want.evicted_slot, got.evicted_slot);
                    check_field("active_count", want.count, got.count);
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(predict_outcome(cmd_t'(s_tdata[1:0]),
                                                          s_tdata[11:2]));
        end
        fail_count <= errs;
        awaited    <= awaited_results.size();
        pool_level <= live;
    end

endmodule

// File: verif/slot_pool_allocator_evict_oldest_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot pool allocator testbench
// Directed commands on an empty pool, then a fill to the full pool, churn at
// the full pool with eviction, and a release-heavy drain, under changing
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module slot_pool_allocator_evict_oldest_top_test;
    import spa_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    int fail_count;
    int awaited;
    int pool_level;
    int send_idle;
    int recv_stall;
    int words_sent;
    int quiet_cycles;

    slot_pool_allocator_evict_oldest_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    slot_pool_checker pool_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .awaited    (awaited),
        .pool_level (pool_level)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the word
    // is accepted, so the valid is never lowered and raised in one step.
    task automatic send_word(cmd_t c, logic [SLOT_W-1:0] s);
        case ((words_sent / 64) % 4)
            0:
            begin
                send_idle = 0;
                recv_stall = 0;
            end
            1:
            begin
                send_idle = 53;
                recv_stall = 0;
            end
            2:
            begin
                send_idle = 0;
                recv_stall = 53;
            end
            default:
            begin
                send_idle = 20;
                recv_stall = 20;
            end
        endcase
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{IN_PAD{1'b0}}, s, c};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    // Weights in percent; what is left over goes to allocate with eviction.
    // Most releases name a low slot, where active slots cluster.
    task automatic send_random(int w_alloc, int w_release, int w_oldest);
        int                r;
        cmd_t              c;
        logic [SLOT_W-1:0] s;
        r = $urandom_range(99);
        if (r < w_alloc)
            c = CMD_ALLOC;
        else if (r < w_alloc + w_release)
            c = CMD_RELEASE;
        else if (r < w_alloc + w_release + w_oldest)
            c = CMD_OLDEST;
        else
            c = CMD_EVICT;
        s = SLOT_W'($urandom_range(1023));
        if (c == CMD_RELEASE && pool_level > 0 && $urandom_range(99) < 75)
            s = SLOT_W'($urandom_range(pool_level - 1));
        send_word(c, s);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        words_sent = 0;
        send_idle = 0;
        recv_stall = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty pool: nothing to release, then a few slots in and out.
        send_word(CMD_OLDEST, 10'd0);
        send_word(CMD_RELEASE, 10'd0);
        send_word(CMD_RELEASE, 10'h3FF);
        send_word(CMD_ALLOC, 10'd0);
        send_word(CMD_ALLOC, 10'h3FF);
        send_word(CMD_EVICT, 10'h2AA);
        send_word(CMD_RELEASE, 10'd1);
        send_word(CMD_RELEASE, 10'd1);
        send_word(CMD_OLDEST, 10'h155);
        send_word(CMD_OLDEST, 10'd0);
        send_word(CMD_OLDEST, 10'h3FF);
        send_word(CMD_RELEASE, 10'h2AA);
        send_word(CMD_RELEASE, 10'h155);
        send_word(CMD_EVICT, 10'h3FF);
        send_word(CMD_RELEASE, 10'd0);

        while (pool_level < SLOTS)
            send_random(60, 1, 0);

        // Full pool: a plain allocate is refused, the evicting one goes through.
        send_word(CMD_ALLOC, 10'h3FF);
        send_word(CMD_EVICT, 10'd0);
        send_word(CMD_OLDEST, 10'd0);
        send_word(CMD_EVICT, 10'h3FF);
        send_word(CMD_EVICT, 10'h155);

        repeat (25) send_random(20, 30, 10);
        repeat (25) send_random(10, 60, 25);

        s_tvalid <= 1'b0;
        while (awaited != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
